// File: rtl/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is low
`define NGLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// signal keeps its value in the cycle after cond
`define NGLM_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// File: rtl/nglm_pkg.sv
// ----------------------------------------------------------------------------
// nglm_pkg
// Request and result types, field widths and helpers for the glyph matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package nglm_pkg;

    localparam int IDX_W    = 7;
    localparam int CODE_W   = 8;
    localparam int CELL_W   = 8;
    localparam int SQ_W     = 2 * CELL_W;
    localparam int DIST_W   = 20;
    localparam int IN_CELLS = 9;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_MATCH = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [CODE_W-1:0] glyph_code;
        logic [CELL_W-1:0] cell_0;
        logic [CELL_W-1:0] cell_1;
        logic [CELL_W-1:0] cell_2;
        logic [CELL_W-1:0] cell_3;
        logic [CELL_W-1:0] cell_4;
        logic [CELL_W-1:0] cell_5;
        logic [CELL_W-1:0] cell_6;
        logic [CELL_W-1:0] cell_7;
        logic [CELL_W-1:0] cell_8;
    } t_in_req;

    typedef struct packed {
        logic [CODE_W-1:0] match_code;
        logic [IDX_W-1:0]  match_index;
        logic [DIST_W-1:0] match_distance_sq;
    } t_out_rsp;

    // grid cell c of a request, cells past the ninth read as zero
    function automatic logic [CELL_W-1:0] in_cell(t_in_req r, int unsigned c);
        case (c)
            0: begin
                return r.cell_0;
            end
            1: begin
                return r.cell_1;
            end
            2: begin
                return r.cell_2;
            end
            3: begin
                return r.cell_3;
            end
            4: begin
                return r.cell_4;
            end
            5: begin
                return r.cell_5;
            end
            6: begin
                return r.cell_6;
            end
            7: begin
                return r.cell_7;
            end
            8: begin
                return r.cell_8;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/nearest_glyph_matcher.sv
// Load request: written into the glyph table at the accepting edge; it does not stall the input.
// Match request: one table entry is read per cycle from the glyph memory and
// goes through a 4-stage read/square/sum/compare pipe; the result is registered
// in S_DONE once the output register is free, and the next request is taken in S_IDLE.
// The result register lets a new request in while the previous result is still stalled.
// Synchronous active-low reset clears control state only; the glyph table is not cleared.
// ----------------------------------------------------------------------------
// nearest_glyph_matcher
// Glyph table plus nearest-entry search by squared Euclidean distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_glyph_matcher import nglm_pkg::*; #(
    parameter int NUM_GLYPHS = 95,
    parameter int GRID_CELLS = 9
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_rsp      o_out_rsp
);

    localparam int AW = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
    localparam int CW = ($clog2(NUM_GLYPHS + 1) > IDX_W) ? $clog2(NUM_GLYPHS + 1) : IDX_W;
    localparam int WW = CODE_W + GRID_CELLS * CELL_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_GLYPHS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CELL_W-1:0] r_grid [GRID_CELLS];

    // glyph table: code in the top byte, cell c at bits c*CELL_W
    logic [WW-1:0]     r_glyph_mem [NUM_GLYPHS];
    logic [WW-1:0]     w_wdata;

    // read stage
    logic              r_v1;
    logic [WW-1:0]     r_rd_word;
    logic [AW-1:0]     r_idx1;
    logic              r_last1;
    // square stage
    logic              r_v2;
    logic [SQ_W-1:0]   r_sq [GRID_CELLS];
    logic [CODE_W-1:0] r_code2;
    logic [AW-1:0]     r_idx2;
    logic              r_last2;
    logic [CELL_W-1:0] w_diff [GRID_CELLS];
    // sum stage
    logic              r_v3;
    logic [DIST_W-1:0] r_dist3;
    logic [CODE_W-1:0] r_code3;
    logic [AW-1:0]     r_idx3;
    logic              r_last3;
    logic [DIST_W-1:0] w_sum;
    // best so far
    logic [DIST_W-1:0] r_best_dist;
    logic [AW-1:0]     r_best_idx;
    logic [CODE_W-1:0] r_best_code;
    logic              w_better;

    logic              r_out_valid;
    t_out_rsp          r_out_rsp;

    logic              w_accept;
    logic              w_idx_ok;
    logic              w_load;
    logic              w_start;
    logic              w_issue;
    logic              w_out_free;
    logic              w_finish;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_idx_ok   = CW'(i_in_req.entry_index) < CW'(NUM_GLYPHS);
    assign w_load     = w_accept && (i_in_req.mode == MODE_LOAD) && w_idx_ok;
    assign w_start    = w_accept && (i_in_req.mode == MODE_MATCH);
    assign w_issue    = (r_state == S_SCAN);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    always_comb begin
        w_wdata = '0;
        w_wdata[WW-1 -: CODE_W] = i_in_req.glyph_code;
        for (int unsigned c = 0; c < GRID_CELLS; c++) begin
            w_wdata[c*CELL_W +: CELL_W] = in_cell(i_in_req, c);
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_DRAIN: begin
                // last entry leaves the compare stage at this edge
                if (r_v3 && r_last3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (w_start) begin
            for (int unsigned c = 0; c < GRID_CELLS; c++) begin
                r_grid[c] <= in_cell(i_in_req, c);
            end
        end
    end

    // table memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_glyph_mem[AW'(i_in_req.entry_index)] <= w_wdata;
        end
        if (w_issue) begin
            r_rd_word <= r_glyph_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= r_addr;
        r_last1 <= (r_addr == LAST_ADDR);
    end

    always_comb begin
        for (int unsigned c = 0; c < GRID_CELLS; c++) begin
            if (r_rd_word[c*CELL_W +: CELL_W] > r_grid[c]) begin
                w_diff[c] = r_rd_word[c*CELL_W +: CELL_W] - r_grid[c];
            end else begin
                w_diff[c] = r_grid[c] - r_rd_word[c*CELL_W +: CELL_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int unsigned c = 0; c < GRID_CELLS; c++) begin
            r_sq[c] <= SQ_W'(w_diff[c]) * SQ_W'(w_diff[c]);
        end
        r_code2 <= r_rd_word[WW-1 -: CODE_W];
        r_idx2  <= r_idx1;
        r_last2 <= r_last1;
    end

    // GRID_CELLS squares of 16 bits; the sum fits 20 bits while GRID_CELLS is at most 16
    always_comb begin
        w_sum = '0;
        for (int unsigned c = 0; c < GRID_CELLS; c++) begin
            w_sum = DIST_W'(w_sum + DIST_W'(r_sq[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist3 <= w_sum;
        r_code3 <= r_code2;
        r_idx3  <= r_idx2;
        r_last3 <= r_last2;
    end

    // entry zero restarts the search, strict less-than keeps the lowest index on ties
    assign w_better = (r_idx3 == '0) || (r_dist3 < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_better) begin
            r_best_dist <= r_dist3;
            r_best_idx  <= r_idx3;
            r_best_code <= r_code3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_rsp.match_code        <= r_best_code;
            r_out_rsp.match_index       <= IDX_W'(r_best_idx);
            r_out_rsp.match_distance_sq <= r_best_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

// File: rtl/nglm_checker.sv
// ----------------------------------------------------------------------------
// nglm_checker
// Port-level checks on the glyph matcher, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nglm_checker import nglm_pkg::*; #(
    parameter int NUM_GLYPHS = 95
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_in_req  i_in_req,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_rsp o_out_rsp
);

    `NGLM_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "stalled result dropped")
    `NGLM_ASSERT_HOLD(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_rsp, "stalled result changed")
    `NGLM_ASSERT(a_match_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_in_req.mode == MODE_MATCH)) |=> o_in_stall, "match request did not start a scan")
    `NGLM_ASSERT(a_load_free, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_in_req.mode == MODE_LOAD)) |=> !o_in_stall, "load request blocked the next request")
    `NGLM_ASSERT(a_idx_range, i_clk, i_rst_n, o_out_valid |-> (32'(o_out_rsp.match_index) < NUM_GLYPHS), "result index outside the table")

endmodule

bind nearest_glyph_matcher nglm_checker #(.NUM_GLYPHS(NUM_GLYPHS)) u_nglm_checker (.*);

`default_nettype wire
